### rtl/hmbs_pkg.sv
// shared types, constants and helper functions for the height map sampler
`default_nettype none
package hmbs_pkg;
    localparam int MAX_GRID_COLS = 256;
    localparam int MAX_GRID_ROWS = 256;
    localparam int COL_W         = $clog2(MAX_GRID_COLS);
    localparam int ROW_W         = $clog2(MAX_GRID_ROWS);
    localparam int SIZE_W        = 9;
    localparam int QUEUE_DEPTH   = 4;
    localparam int BANK_DEPTH    = (MAX_GRID_COLS / 2) * (MAX_GRID_ROWS / 2);
    localparam int BANK_AW       = COL_W + ROW_W - 2;

    localparam logic [16:0] ONE_Q16 = 17'h10000;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_HEIGHT = 2'd1,
        OP_GRAD   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        REG_INV_X_SCALE   = 3'd0,
        REG_INV_Y_SCALE   = 3'd1,
        REG_Z_SCALE       = 3'd2,
        REG_X_OFFSET      = 3'd3,
        REG_Y_OFFSET      = 3'd4,
        REG_GRID_WIDTH    = 3'd5,
        REG_GRID_HEIGHT   = 3'd6,
        REG_UNIFORM_DEPTH = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [23:0]        inv_x_scale;
        logic [23:0]        inv_y_scale;
        logic signed [23:0] z_scale;
        logic signed [31:0] x_offset;
        logic signed [31:0] y_offset;
        logic [SIZE_W-1:0]  grid_width;
        logic [SIZE_W-1:0]  grid_height;
        logic signed [31:0] uniform_depth;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  lo_idx;
        logic [7:0]  hi_idx;
        logic [16:0] w_lo;
        logic [16:0] w_hi;
        logic        outside;
    } axis_t;

    typedef struct packed {
        op_t        op;
        axis_t      ax;
        axis_t      ay;
        logic       uniform;
        logic [7:0] cell_value;
    } req_t;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] lim);
        logic [SIZE_W-1:0] r;
        r = v;
        if (v == '0)
            r = SIZE_W'(1);
        else if (v > lim)
            r = lim;
        return r;
    endfunction

    function automatic axis_t map_axis(input logic signed [55:0] prod,
                                       input logic signed [31:0] off,
                                       input logic [SIZE_W-1:0] size);
        axis_t              a;
        logic signed [40:0] pos;
        logic signed [25:0] fl;
        logic signed [25:0] ce;
        logic [15:0]        fr;
        logic [SIZE_W-1:0]  lim;
        logic signed [25:0] lim_s;
        logic signed [40:0] lim_q;
        logic signed [40:0] size_q;
        pos    = {prod[55], prod[55:16]} - {{9{off[31]}}, off};
        fl     = {pos[40], pos[40:16]};
        fr     = pos[15:0];
        ce     = fl + 26'(fr != 16'd0);
        lim    = size - SIZE_W'(1);
        lim_s  = $signed({{(26-SIZE_W){1'b0}}, lim});
        lim_q  = $signed({{(25-SIZE_W){1'b0}}, lim, 16'd0});
        size_q = $signed({{(25-SIZE_W){1'b0}}, size, 16'd0});
        if (fl < 0)
            a.lo_idx = 8'd0;
        else if (fl > lim_s)
            a.lo_idx = lim[7:0];
        else
            a.lo_idx = fl[7:0];
        if (ce < 0)
            a.hi_idx = 8'd0;
        else if (ce > lim_s)
            a.hi_idx = lim[7:0];
        else
            a.hi_idx = ce[7:0];
        if (pos <= 0)
        begin
            a.w_lo = ONE_Q16;
            a.w_hi = 17'd0;
        end
        else if (pos >= lim_q)
        begin
            a.w_lo = 17'd0;
            a.w_hi = ONE_Q16;
        end
        else
        begin
            a.w_lo = ONE_Q16 - {1'b0, fr};
            a.w_hi = {1'b0, fr};
        end
        a.outside = (pos < 0) || (pos > size_q);
        return a;
    endfunction
endpackage
`default_nettype wire

### rtl/hmbs_if.sv
// request and result channel interfaces
`default_nettype none
interface hmbs_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
    logic [7:0]         cell_col;
    logic [7:0]         cell_row;
    logic [7:0]         cell_value;
    modport source (output valid, func, x_coord, y_coord, cell_col, cell_row, cell_value,
                    input ready);
    modport sink (input valid, func, x_coord, y_coord, cell_col, cell_row, cell_value,
                  output ready);
endinterface

interface hmbs_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [39:0] surface_height;
    logic signed [39:0] grad_x;
    logic signed [39:0] grad_y;
    logic               outside_grid;
    modport source (output valid, surface_height, grad_x, grad_y, outside_grid,
                    input ready);
    modport sink (input valid, surface_height, grad_x, grad_y, outside_grid,
                  output ready);
endinterface
`default_nettype wire

### rtl/height_map_bilinear_sampler.sv
// top level of the height map bilinear sampler
// pipeline: 2 front stages, then the request queue, then 5 back stages
// throughput: one request per cycle while rsp.ready does not stall; the four grid corners come
// from four banks split by column and row parity, so each bank is read once per request
// reset: control and config registers return to defaults, the grid is undefined until written
`default_nettype none
module height_map_bilinear_sampler (
    input  wire logic        clk,
    input  wire logic        rst_n,
    hmbs_req_if.sink         req,
    hmbs_rsp_if.source       rsp,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_idx,
    input  wire logic [31:0] cfg_data
);
    hmbs_pkg::cfg_t cfg_reg;
    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_empty;
    hmbs_pkg::req_t q_in;
    hmbs_pkg::req_t q_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.inv_x_scale   <= 24'd65536;
            cfg_reg.inv_y_scale   <= 24'd65536;
            cfg_reg.z_scale       <= 24'sd65536;
            cfg_reg.x_offset      <= '0;
            cfg_reg.y_offset      <= '0;
            cfg_reg.grid_width    <= hmbs_pkg::SIZE_W'(1);
            cfg_reg.grid_height   <= hmbs_pkg::SIZE_W'(1);
            cfg_reg.uniform_depth <= '0;
        end
        else if (cfg_we)
        begin
            case (hmbs_pkg::reg_idx_t'(cfg_idx))
                hmbs_pkg::REG_INV_X_SCALE:   cfg_reg.inv_x_scale   <= cfg_data[23:0];
                hmbs_pkg::REG_INV_Y_SCALE:   cfg_reg.inv_y_scale   <= cfg_data[23:0];
                hmbs_pkg::REG_Z_SCALE:       cfg_reg.z_scale       <= cfg_data[23:0];
                hmbs_pkg::REG_X_OFFSET:      cfg_reg.x_offset      <= cfg_data;
                hmbs_pkg::REG_Y_OFFSET:      cfg_reg.y_offset      <= cfg_data;
                hmbs_pkg::REG_GRID_WIDTH:    cfg_reg.grid_width    <= cfg_data[8:0];
                hmbs_pkg::REG_GRID_HEIGHT:   cfg_reg.grid_height   <= cfg_data[8:0];
                hmbs_pkg::REG_UNIFORM_DEPTH: cfg_reg.uniform_depth <= cfg_data;
                default:                     cfg_reg               <= cfg_reg;
            endcase
        end
    end

    hmbs_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .cfg    (cfg_reg),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_in)
    );

    hmbs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    hmbs_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_empty (q_empty),
        .q_data  (q_out),
        .q_pop   (q_pop),
        .rsp     (rsp)
    );
endmodule
`default_nettype wire

### rtl/hmbs_front.sv
// front end: coordinate mapping, cell index and weight computation
`default_nettype none
module hmbs_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    hmbs_req_if.sink           req,
    input  wire hmbs_pkg::cfg_t cfg,
    input  wire logic          q_full,
    output logic               q_push,
    output hmbs_pkg::req_t     q_data
);
    logic               adv;
    logic               f1_v_reg;
    hmbs_pkg::op_t      f1_op_reg;
    logic signed [55:0] f1_px_reg;
    logic signed [55:0] f1_py_reg;
    logic [7:0]         f1_col_reg;
    logic [7:0]         f1_row_reg;
    logic [7:0]         f1_val_reg;
    logic               f2_v_reg;
    hmbs_pkg::req_t     f2_q_reg;
    hmbs_pkg::req_t     f2_q_next;
    logic [hmbs_pkg::SIZE_W-1:0] w_use;
    logic [hmbs_pkg::SIZE_W-1:0] h_use;

    assign adv       = !f2_v_reg || !q_full;
    assign req.ready = adv;
    assign q_push    = f2_v_reg && !q_full;
    assign q_data    = f2_q_reg;

    assign w_use = hmbs_pkg::clamp_size(cfg.grid_width,
                                        hmbs_pkg::SIZE_W'(hmbs_pkg::MAX_GRID_COLS));
    assign h_use = hmbs_pkg::clamp_size(cfg.grid_height,
                                        hmbs_pkg::SIZE_W'(hmbs_pkg::MAX_GRID_ROWS));

    always_comb
    begin
        f2_q_next            = '0;
        f2_q_next.op         = f1_op_reg;
        f2_q_next.cell_value = f1_val_reg;
        f2_q_next.uniform    = (w_use == hmbs_pkg::SIZE_W'(1)) &&
                               (h_use == hmbs_pkg::SIZE_W'(1));
        if (f1_op_reg == hmbs_pkg::OP_WRITE)
        begin
            f2_q_next.ax.lo_idx = f1_col_reg;
            f2_q_next.ay.lo_idx = f1_row_reg;
        end
        else
        begin
            f2_q_next.ax = hmbs_pkg::map_axis(f1_px_reg, cfg.x_offset, w_use);
            f2_q_next.ay = hmbs_pkg::map_axis(f1_py_reg, cfg.y_offset, h_use);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_v_reg <= 1'b0;
            f2_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            f1_v_reg <= req.valid && (hmbs_pkg::op_t'(req.func) != hmbs_pkg::OP_NONE);
            f2_v_reg <= f1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f1_op_reg  <= hmbs_pkg::op_t'(req.func);
            f1_px_reg  <= req.x_coord * $signed({1'b0, cfg.inv_x_scale});
            f1_py_reg  <= req.y_coord * $signed({1'b0, cfg.inv_y_scale});
            f1_col_reg <= req.cell_col;
            f1_row_reg <= req.cell_row;
            f1_val_reg <= req.cell_value;
            f2_q_reg   <= f2_q_next;
        end
    end

    a_idx_adjacent: assert property (@(posedge clk) disable iff (!rst_n)
        f2_v_reg && (f2_q_reg.op != hmbs_pkg::OP_WRITE) |->
            (f2_q_reg.ax.hi_idx >= f2_q_reg.ax.lo_idx) &&
            (f2_q_reg.ax.hi_idx - f2_q_reg.ax.lo_idx <= 8'd1))
        else $error("column indices not adjacent");
endmodule
`default_nettype wire

### rtl/hmbs_queue.sv
// request queue between front and back end
`default_nettype none
module hmbs_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire hmbs_pkg::req_t push_data,
    output logic                full,
    input  wire logic           pop,
    output hmbs_pkg::req_t      pop_data,
    output logic                empty
);
    localparam int AW = $clog2(hmbs_pkg::QUEUE_DEPTH);

    hmbs_pkg::req_t entry_reg [hmbs_pkg::QUEUE_DEPTH];
    logic [AW-1:0]  wptr_reg;
    logic [AW-1:0]  rptr_reg;
    logic [AW:0]    count_reg;
    logic [AW:0]    count_next;

    assign full     = count_reg == (AW+1)'(hmbs_pkg::QUEUE_DEPTH);
    assign empty    = count_reg == '0;
    assign pop_data = entry_reg[rptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + (AW+1)'(1);
        else if (pop && !push)
            count_next = count_reg - (AW+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wptr_reg <= wptr_reg + AW'(1);
            if (pop)
                rptr_reg <= rptr_reg + AW'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wptr_reg] <= push_data;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("pop from empty queue");
endmodule
`default_nettype wire

### rtl/hmbs_back.sv
// back end: banked grid memory, interpolation and output scaling
`default_nettype none
module hmbs_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire hmbs_pkg::cfg_t cfg,
    input  wire logic           q_empty,
    input  wire hmbs_pkg::req_t q_data,
    output logic                q_pop,
    hmbs_rsp_if.source          rsp
);
    localparam int AW = hmbs_pkg::BANK_AW;
    localparam int HC = hmbs_pkg::COL_W - 1;

    logic adv;
    logic is_write;
    logic is_query;

    logic [7:0]     rd_reg [4];
    logic           s1_v_reg;
    hmbs_pkg::req_t s1_q_reg;

    logic [7:0] h_ll;
    logic [7:0] h_hl;
    logic [7:0] h_lh;
    logic [7:0] h_hh;

    logic                      s2_v_reg;
    hmbs_pkg::op_t             s2_op_reg;
    logic                      s2_out_reg;
    logic                      s2_uni_reg;
    logic [16:0]               s2_wylo_reg;
    logic [16:0]               s2_wyhi_reg;
    logic [25:0]               s2_rl_reg;
    logic [25:0]               s2_rh_reg;
    logic signed [27:0]        s2_gx_reg;
    logic signed [27:0]        s2_gy_reg;

    logic                      s3_v_reg;
    hmbs_pkg::op_t             s3_op_reg;
    logic                      s3_out_reg;
    logic                      s3_uni_reg;
    logic signed [27:0]        s3_hv_reg;
    logic signed [27:0]        s3_gx_reg;
    logic signed [27:0]        s3_gy_reg;
    logic [43:0]               acc;

    logic                      s4_v_reg;
    hmbs_pkg::op_t             s4_op_reg;
    logic                      s4_out_reg;
    logic                      s4_uni_reg;
    logic signed [51:0]        s4_m0_reg;
    logic signed [51:0]        s4_m1_reg;

    logic                      o_v_reg;
    logic signed [39:0]        o_h_reg;
    logic signed [39:0]        o_gx_reg;
    logic signed [39:0]        o_gy_reg;
    logic                      o_out_reg;
    logic signed [39:0]        o_h_next;
    logic signed [39:0]        o_gx_next;
    logic signed [39:0]        o_gy_next;
    logic                      o_out_next;
    logic signed [51:0]        r0;
    logic signed [51:0]        r1;

    assign adv      = !o_v_reg || rsp.ready;
    assign q_pop    = adv && !q_empty;
    assign is_write = q_pop && (q_data.op == hmbs_pkg::OP_WRITE);
    assign is_query = q_pop && (q_data.op != hmbs_pkg::OP_WRITE);

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        logic [7:0]    mem [hmbs_pkg::BANK_DEPTH];
        logic [7:0]    col;
        logic [7:0]    row;
        logic [AW-1:0] raddr;
        logic [AW-1:0] waddr;
        logic          we;

        assign col   = (q_data.ax.lo_idx[0] == b[0]) ? q_data.ax.lo_idx : q_data.ax.hi_idx;
        assign row   = (q_data.ay.lo_idx[0] == b[1]) ? q_data.ay.lo_idx : q_data.ay.hi_idx;
        assign raddr = {row[7:1], col[HC:1]};
        assign waddr = {q_data.ay.lo_idx[7:1], q_data.ax.lo_idx[HC:1]};
        assign we    = is_write && (q_data.ax.lo_idx[0] == b[0]) &&
                       (q_data.ay.lo_idx[0] == b[1]);

        always_ff @(posedge clk)
        begin
            if (we)
                mem[waddr] <= q_data.cell_value;
            if (adv)
                rd_reg[b] <= mem[raddr];
        end
    end

    assign h_ll = rd_reg[{s1_q_reg.ay.lo_idx[0], s1_q_reg.ax.lo_idx[0]}];
    assign h_hl = rd_reg[{s1_q_reg.ay.lo_idx[0], s1_q_reg.ax.hi_idx[0]}];
    assign h_lh = rd_reg[{s1_q_reg.ay.hi_idx[0], s1_q_reg.ax.lo_idx[0]}];
    assign h_hh = rd_reg[{s1_q_reg.ay.hi_idx[0], s1_q_reg.ax.hi_idx[0]}];

    assign acc = 44'(s2_wylo_reg * s2_rl_reg) + 44'(s2_wyhi_reg * s2_rh_reg);
    assign r0  = s4_m0_reg + 52'sd32768;
    assign r1  = s4_m1_reg + 52'sd32768;

    always_comb
    begin
        o_h_next   = '0;
        o_gx_next  = '0;
        o_gy_next  = '0;
        o_out_next = 1'b0;
        if (s4_op_reg == hmbs_pkg::OP_HEIGHT)
        begin
            if (s4_uni_reg)
                o_h_next = 40'(cfg.uniform_depth);
            else
                o_h_next = 40'(r0 >>> 16);
        end
        else if (s4_out_reg)
            o_out_next = 1'b1;
        else
        begin
            o_gx_next = 40'(r0 >>> 16);
            o_gy_next = 40'(r1 >>> 16);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
            o_v_reg  <= 1'b0;
        end
        else if (adv)
        begin
            s1_v_reg <= is_query;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
            o_v_reg  <= s4_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_q_reg <= q_data;

            s2_op_reg   <= s1_q_reg.op;
            s2_out_reg  <= s1_q_reg.ax.outside || s1_q_reg.ay.outside;
            s2_uni_reg  <= s1_q_reg.uniform;
            s2_wylo_reg <= s1_q_reg.ay.w_lo;
            s2_wyhi_reg <= s1_q_reg.ay.w_hi;
            s2_rl_reg   <= 26'(s1_q_reg.ax.w_lo * h_ll) + 26'(s1_q_reg.ax.w_hi * h_hl);
            s2_rh_reg   <= 26'(s1_q_reg.ax.w_lo * h_lh) + 26'(s1_q_reg.ax.w_hi * h_hh);
            s2_gx_reg   <= 28'($signed({1'b0, s1_q_reg.ay.w_lo}) *
                               ($signed({1'b0, h_hl}) - $signed({1'b0, h_ll})))
                         + 28'($signed({1'b0, s1_q_reg.ay.w_hi}) *
                               ($signed({1'b0, h_hh}) - $signed({1'b0, h_lh})));
            s2_gy_reg   <= 28'($signed({1'b0, s1_q_reg.ax.w_lo}) *
                               ($signed({1'b0, h_lh}) - $signed({1'b0, h_ll})))
                         + 28'($signed({1'b0, s1_q_reg.ax.w_hi}) *
                               ($signed({1'b0, h_hh}) - $signed({1'b0, h_hl})));

            s3_op_reg  <= s2_op_reg;
            s3_out_reg <= s2_out_reg;
            s3_uni_reg <= s2_uni_reg;
            s3_hv_reg  <= $signed(28'(({16'd0, acc} + 60'd32768) >> 16));
            s3_gx_reg  <= s2_gx_reg;
            s3_gy_reg  <= s2_gy_reg;

            s4_op_reg  <= s3_op_reg;
            s4_out_reg <= s3_out_reg;
            s4_uni_reg <= s3_uni_reg;
            s4_m0_reg  <= ((s3_op_reg == hmbs_pkg::OP_HEIGHT) ? s3_hv_reg : s3_gx_reg)
                          * cfg.z_scale;
            s4_m1_reg  <= s3_gy_reg * cfg.z_scale;

            o_h_reg   <= o_h_next;
            o_gx_reg  <= o_gx_next;
            o_gy_reg  <= o_gy_next;
            o_out_reg <= o_out_next;
        end
    end

    assign rsp.valid          = o_v_reg;
    assign rsp.surface_height = o_h_reg;
    assign rsp.grad_x         = o_gx_reg;
    assign rsp.grad_y         = o_gy_reg;
    assign rsp.outside_grid   = o_out_reg;

    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        o_v_reg && o_out_reg |-> (o_gx_reg == '0) && (o_gy_reg == '0) && (o_h_reg == '0))
        else $error("outside result carries data");
    a_pop_adv: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> adv)
        else $error("queue popped while back end stalled");
endmodule
`default_nettype wire
